// ===== design/pts_pkg.sv =====
// Shared types and constants of the priority task scheduler.
// No dependencies; every other design file imports this package.
package pts_pkg;

	localparam int TASK_SLOTS  = 16;
	localparam int PRIO_LEVELS = 32;
	localparam int TASK_W      = 4;
	localparam int PRIO_W      = 5;
	localparam int TID_W       = $clog2(TASK_SLOTS);
	localparam int POS_W       = $clog2(TASK_SLOTS);
	localparam int CNT_W       = $clog2(TASK_SLOTS + 1);
	localparam logic [7:0] LOCK_MAX     = 8'd255;
	localparam logic [7:0] SLICE_RESET  = 8'd10;

	typedef enum logic [3:0] {
		CMD_READY    = 4'd0,
		CMD_UNREADY  = 4'd1,
		CMD_DELAY    = 4'd2,
		CMD_WAKE     = 4'd3,
		CMD_TICK     = 4'd4,
		CMD_LOCK     = 4'd5,
		CMD_UNLOCK   = 4'd6,
		CMD_SCHEDULE = 4'd7,
		CMD_START    = 4'd8
	} cmd_t;

	typedef enum logic [3:0] {
		OP_NONE, OP_LATCH, OP_QREM, OP_QADD, OP_DREM, OP_DAPP, OP_FIND, OP_DEC,
		OP_IDXINC, OP_ROT, OP_BEST, OP_PICK, OP_LOCK, OP_UNLOCK, OP_NOTE, OP_FINAL
	} op_t;

	typedef enum logic [4:0] {
		S_IDLE, S_DISP, S_QREM, S_QADD, S_DREM, S_DAPP, S_TFIND, S_TDEC, S_TCHK,
		S_TNOTE, S_TDREM, S_TQREM, S_TQADD, S_ROT, S_BEST, S_PICK, S_FIN
	} state_t;

	typedef struct packed {
		op_t  op;
		logic slot_prio;
	} ctl_t;

	typedef struct packed {
		cmd_t cmd;
		logic slot_ok;
		logic lock_zero;
		logic lock_one;
		logic found;
		logic expired;
		logic waiting;
		logic out_busy;
	} stat_t;

endpackage

// ===== design/pts_if.sv =====
// Channel interfaces of the priority task scheduler: command, result, config.
// Depends on pts_pkg.
interface pts_cmd_if import pts_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [3:0]          command;
	logic [TASK_W-1:0]   task_id;
	logic [PRIO_W-1:0]   ready_priority;
	logic [31:0]         delay_ticks;
	logic                waits_event;
	modport source (output valid, command, task_id, ready_priority, delay_ticks,
		waits_event, input ready);
	modport sink (input valid, command, task_id, ready_priority, delay_ticks,
		waits_event, output ready);
endinterface

interface pts_res_if import pts_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              kind;
	logic [TASK_W-1:0] task_out;
	logic              switched;
	logic [7:0]        lock_level;
	logic              last;
	modport source (output valid, kind, task_out, switched, lock_level, last,
		input ready);
	modport sink (input valid, kind, task_out, switched, lock_level, last,
		output ready);
endinterface

interface pts_cfg_if ();
	logic       valid;
	logic       ready;
	logic [7:0] data;
	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

// ===== design/pts_ctrl.sv =====
// Sequencer of the priority task scheduler: walks each command through its steps.
// Depends on pts_pkg; drives pts_dp through ctl_t, watches stat_t.
module pts_ctrl import pts_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  stat_t stat,
	output ctl_t  ctl
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		ctl.op        = OP_NONE;
		ctl.slot_prio = 1'b0;
		in_ready      = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					ctl.op  = OP_LATCH;
					state_d = S_DISP;
				end
			end
			S_DISP: begin
				case (stat.cmd)
					CMD_READY, CMD_UNREADY: state_d = stat.slot_ok ? S_QREM : S_FIN;
					CMD_DELAY, CMD_WAKE:    state_d = stat.slot_ok ? S_DREM : S_FIN;
					CMD_TICK:               state_d = S_TFIND;
					CMD_LOCK: begin
						ctl.op  = OP_LOCK;
						state_d = S_FIN;
					end
					CMD_UNLOCK: begin
						ctl.op  = OP_UNLOCK;
						state_d = stat.lock_one ? S_BEST : S_FIN;
					end
					CMD_SCHEDULE:           state_d = stat.lock_zero ? S_BEST : S_FIN;
					CMD_START:              state_d = S_BEST;
					default:                state_d = S_FIN;
				endcase
			end
			S_QREM: begin
				ctl.op  = OP_QREM;
				state_d = (stat.cmd == CMD_READY) ? S_QADD : S_FIN;
			end
			S_QADD: begin
				ctl.op  = OP_QADD;
				state_d = S_FIN;
			end
			S_DREM: begin
				ctl.op  = OP_DREM;
				state_d = (stat.cmd == CMD_DELAY) ? S_DAPP : S_FIN;
			end
			S_DAPP: begin
				ctl.op  = OP_DAPP;
				state_d = S_FIN;
			end
			S_TFIND: begin
				if (stat.found) begin
					ctl.op  = OP_FIND;
					state_d = S_TDEC;
				end else begin
					state_d = S_ROT;
				end
			end
			S_TDEC: begin
				ctl.op  = OP_DEC;
				state_d = S_TCHK;
			end
			S_TCHK: begin
				if (!stat.expired) begin
					ctl.op  = OP_IDXINC;
					state_d = S_TFIND;
				end else if (stat.waiting) begin
					state_d = S_TNOTE;
				end else begin
					state_d = S_TDREM;
				end
			end
			S_TNOTE: begin
				if (!stat.out_busy) begin
					ctl.op  = OP_NOTE;
					state_d = S_TDREM;
				end
			end
			S_TDREM: begin
				ctl.op  = OP_DREM;
				state_d = S_TQREM;
			end
			S_TQREM: begin
				ctl.op  = OP_QREM;
				state_d = S_TQADD;
			end
			S_TQADD: begin
				ctl.op        = OP_QADD;
				ctl.slot_prio = 1'b1;
				state_d       = S_TFIND;
			end
			S_ROT: begin
				ctl.op  = OP_ROT;
				state_d = stat.lock_zero ? S_BEST : S_FIN;
			end
			S_BEST: begin
				ctl.op  = OP_BEST;
				state_d = S_PICK;
			end
			S_PICK: begin
				ctl.op  = OP_PICK;
				state_d = S_FIN;
			end
			S_FIN: begin
				if (!stat.out_busy) begin
					ctl.op  = OP_FINAL;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

// ===== design/pts_dp.sv =====
// Datapath of the priority task scheduler: per-task lanes, counters, result register.
// Depends on pts_pkg; commanded by pts_ctrl.
module pts_dp import pts_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [3:0]        command,
	input  logic [TASK_W-1:0] task_id,
	input  logic [PRIO_W-1:0] ready_priority,
	input  logic [31:0]       delay_ticks,
	input  logic              waits_event,
	input  logic              cfg_valid,
	input  logic [7:0]        cfg_data,
	input  ctl_t              ctl,
	output stat_t             stat,
	input  logic              out_ready,
	output logic              out_valid,
	output logic              kind,
	output logic [TASK_W-1:0] task_out,
	output logic              switched,
	output logic [7:0]        lock_level,
	output logic              last
);

	// command latch
	cmd_t              cmd_q;
	logic              slot_ok_q;
	logic [PRIO_W-1:0] prio_q;
	logic [31:0]       ticks_q;
	logic              waits_q;
	logic [TID_W-1:0]  before_q, tgt_q, running_q;
	logic [CNT_W-1:0]  idx_q;
	logic              expired_q, any_q;
	logic [PRIO_W-1:0] best_q;
	logic [7:0]        lock_q, reload_q;
	logic [31:0]       tick_total_q;

	// per-task lanes
	logic              inq_q   [TASK_SLOTS];
	logic [POS_W-1:0]  qpos_q  [TASK_SLOTS];
	logic [PRIO_W-1:0] sprio_q [TASK_SLOTS];
	logic              dly_q   [TASK_SLOTS];
	logic [POS_W-1:0]  dpos_q  [TASK_SLOTS];
	logic [31:0]       sdelay_q[TASK_SLOTS];
	logic              swait_q [TASK_SLOTS];
	logic [7:0]        slice_q [TASK_SLOTS];

	logic              ov_q, okind_q, osw_q, olast_q;
	logic [TASK_W-1:0] otask_q;
	logic [7:0]        olock_q;

	logic [PRIO_W-1:0] rm_p, add_p, rot_p, best_d;
	logic [POS_W-1:0]  rm_pos;
	logic [CNT_W-1:0]  dlen, rot_n;
	logic              found, any_d, rot_do;
	logic [TID_W-1:0]  sel, head;
	logic [7:0]        new_slice;
	logic [PRIO_LEVELS-1:0] bitmap;

	always_comb begin
		rm_p      = sprio_q[tgt_q];
		rm_pos    = qpos_q[tgt_q];
		add_p     = ctl.slot_prio ? sprio_q[tgt_q] : prio_q;
		rot_p     = sprio_q[running_q];
		new_slice = slice_q[running_q] - 8'd1;
		dlen      = '0;
		rot_n     = '0;
		found     = 1'b0;
		sel       = '0;
		head      = '0;
		bitmap    = '0;
		for (int u = 0; u < TASK_SLOTS; u++) begin
			if (dly_q[u]) begin
				dlen = dlen + CNT_W'(1);
				if (CNT_W'(dpos_q[u]) == idx_q) begin
					found = 1'b1;
					sel   = TID_W'(u);
				end
			end
			if (inq_q[u]) begin
				bitmap[sprio_q[u]] = 1'b1;
				if (sprio_q[u] == rot_p)
					rot_n = rot_n + CNT_W'(1);
				if (sprio_q[u] == best_q && qpos_q[u] == '0)
					head = TID_W'(u);
			end
		end
		rot_do = (new_slice == 8'd0) && (rot_n != '0);
		any_d  = |bitmap;
		best_d = '0;
		for (int p = PRIO_LEVELS - 1; p >= 0; p--) begin
			if (bitmap[p])
				best_d = PRIO_W'(p);
		end
	end

	always_comb begin
		stat.cmd       = cmd_q;
		stat.slot_ok   = slot_ok_q;
		stat.lock_zero = (lock_q == 8'd0);
		stat.lock_one  = (lock_q == 8'd1);
		stat.found     = found;
		stat.expired   = expired_q;
		stat.waiting   = swait_q[tgt_q];
		stat.out_busy  = ov_q && !out_ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_q        <= CMD_READY;
			running_q    <= '0;
			lock_q       <= '0;
			reload_q     <= SLICE_RESET;
			tick_total_q <= '0;
			ov_q         <= 1'b0;
			for (int u = 0; u < TASK_SLOTS; u++) begin
				inq_q[u]   <= 1'b0;
				dly_q[u]   <= 1'b0;
				swait_q[u] <= 1'b0;
				sprio_q[u] <= '0;
				slice_q[u] <= SLICE_RESET;
			end
		end else begin
			if (cfg_valid)
				reload_q <= cfg_data;
			// new word loads over a taken one in the same cycle
			if (ctl.op == OP_NOTE || ctl.op == OP_FINAL)
				ov_q <= 1'b1;
			else if (out_ready)
				ov_q <= 1'b0;
			case (ctl.op)
				OP_LATCH: begin
					cmd_q     <= cmd_t'(command);
					slot_ok_q <= (32'(task_id) < TASK_SLOTS);
					prio_q    <= (32'(ready_priority) >= PRIO_LEVELS) ?
						PRIO_W'(PRIO_LEVELS - 1) : ready_priority;
					ticks_q   <= delay_ticks;
					waits_q   <= waits_event;
					tgt_q     <= TID_W'(task_id);
					before_q  <= running_q;
					idx_q     <= '0;
				end
				OP_QREM: begin
					if (inq_q[tgt_q]) begin
						for (int u = 0; u < TASK_SLOTS; u++)
							if (inq_q[u] && sprio_q[u] == rm_p && qpos_q[u] > rm_pos)
								qpos_q[u] <= qpos_q[u] - POS_W'(1);
						inq_q[tgt_q] <= 1'b0;
					end
				end
				OP_QADD: begin
					for (int u = 0; u < TASK_SLOTS; u++)
						if (inq_q[u] && sprio_q[u] == add_p)
							qpos_q[u] <= qpos_q[u] + POS_W'(1);
					sprio_q[tgt_q] <= add_p;
					inq_q[tgt_q]   <= 1'b1;
					qpos_q[tgt_q]  <= '0;
				end
				OP_DREM: begin
					if (dly_q[tgt_q]) begin
						for (int u = 0; u < TASK_SLOTS; u++)
							if (dly_q[u] && dpos_q[u] > dpos_q[tgt_q])
								dpos_q[u] <= dpos_q[u] - POS_W'(1);
						dly_q[tgt_q] <= 1'b0;
					end
				end
				OP_DAPP: begin
					sdelay_q[tgt_q] <= ticks_q;
					swait_q[tgt_q]  <= waits_q;
					dpos_q[tgt_q]   <= POS_W'(dlen);
					dly_q[tgt_q]    <= 1'b1;
				end
				OP_FIND:   tgt_q <= sel;
				OP_DEC: begin
					sdelay_q[tgt_q] <= sdelay_q[tgt_q] - 32'd1;
					expired_q       <= (sdelay_q[tgt_q] == 32'd1);
				end
				OP_IDXINC: idx_q <= idx_q + CNT_W'(1);
				OP_ROT: begin
					slice_q[running_q] <= rot_do ? reload_q : new_slice;
					if (rot_do) begin
						for (int u = 0; u < TASK_SLOTS; u++)
							if (inq_q[u] && sprio_q[u] == rot_p)
								qpos_q[u] <= (qpos_q[u] == '0) ?
									POS_W'(rot_n - CNT_W'(1)) : qpos_q[u] - POS_W'(1);
					end
					tick_total_q <= tick_total_q + 32'd1;
				end
				OP_BEST: begin
					best_q <= best_d;
					any_q  <= any_d;
				end
				OP_PICK: begin
					if (any_q)
						running_q <= head;
				end
				OP_LOCK: begin
					if (lock_q != LOCK_MAX)
						lock_q <= lock_q + 8'd1;
				end
				OP_UNLOCK: begin
					if (lock_q != 8'd0)
						lock_q <= lock_q - 8'd1;
				end
				OP_NOTE: begin
					swait_q[tgt_q] <= 1'b0;
					okind_q <= 1'b0;
					otask_q <= TASK_W'(tgt_q);
					osw_q   <= 1'b0;
					olock_q <= 8'd0;
					olast_q <= 1'b0;
				end
				OP_FINAL: begin
					okind_q <= 1'b1;
					otask_q <= TASK_W'(running_q);
					osw_q   <= (running_q != before_q);
					olock_q <= lock_q;
					olast_q <= 1'b1;
				end
				default: ;
			endcase
		end
	end

	assign out_valid  = ov_q;
	assign kind       = okind_q;
	assign task_out   = otask_q;
	assign switched   = osw_q;
	assign lock_level = olock_q;
	assign last       = olast_q;

endmodule

// ===== design/priority_task_scheduler_unit.sv =====
// Priority task scheduler, top level: a sequencer (pts_ctrl) and a lane datapath (pts_dp).
// Depends on pts_pkg and the channel interfaces in pts_if.sv.
//
// Commands arrive one word at a time on cmd; each yields zero or more event-timeout
// notices followed by one final status word on res. Commands are handled one at a
// time. A tick walks the delay list one entry at a time through the shared lane
// logic and sends one timeout notice for each expired task that waits on an event.
// A new command is taken as soon as the previous final status sits in the result
// register, even if not yet taken; a stalled result channel holds the sequencer only
// when another word must go out.
// The user must write the time slice reload value on cfg only while the block is idle; the block does not enforce it.
module priority_task_scheduler_unit import pts_pkg::*; (
	input logic   clk,
	input logic   arst_n,
	pts_cmd_if.sink   cmd,
	pts_res_if.source res,
	pts_cfg_if.sink   cfg
);

	ctl_t  ctl;
	stat_t stat;

	assign cfg.ready = 1'b1;   // register write always taken

	pts_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (cmd.valid),
		.in_ready (cmd.ready),
		.stat     (stat),
		.ctl      (ctl)
	);

	pts_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.command        (cmd.command),
		.task_id        (cmd.task_id),
		.ready_priority (cmd.ready_priority),
		.delay_ticks    (cmd.delay_ticks),
		.waits_event    (cmd.waits_event),
		.cfg_valid      (cfg.valid),
		.cfg_data       (cfg.data),
		.ctl            (ctl),
		.stat           (stat),
		.out_ready      (res.ready),
		.out_valid      (res.valid),
		.kind           (res.kind),
		.task_out       (res.task_out),
		.switched       (res.switched),
		.lock_level     (res.lock_level),
		.last           (res.last)
	);

endmodule

// ===== sim/tb_priority_task_scheduler_unit.sv =====
// Testbench for priority_task_scheduler_unit: directed and random command streams checked
// word by word against a behavioural scheduler model held in the bench.
// Depends on pts_pkg, the channel interfaces in pts_if.sv and the design itself.
`timescale 1ns / 100ps

module tb_priority_task_scheduler_unit;
	import pts_pkg::*;

	typedef struct {
		bit       kind;
		bit [3:0] tsk;
		bit       sw;
		bit [7:0] lvl;
		bit       fin;
	} status_word_t;

	logic clk;
	logic arst_n;

	pts_cmd_if cmd ();
	pts_res_if res ();
	pts_cfg_if cfg ();

	priority_task_scheduler_unit u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd.sink),
		.res    (res.source),
		.cfg    (cfg.sink)
	);

	// clock: 20 ns period
	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// ---------------------------------------------------------------
	// Scheduler model: ready queues, delay list, slices, lock, running task
	// ---------------------------------------------------------------
	bit [3:0]  rq_slot [PRIO_LEVELS][TASK_SLOTS];
	int        rq_len [PRIO_LEVELS];
	bit [4:0]  task_prio [TASK_SLOTS];
	bit [3:0]  dl_slot [TASK_SLOTS];
	int        dl_len;
	bit [31:0] task_wait [TASK_SLOTS];
	bit        task_evt [TASK_SLOTS];
	bit [7:0]  task_slice [TASK_SLOTS];
	bit [3:0]  running;
	bit [7:0]  lock_depth;
	bit [7:0]  slice_value;

	// slots whose priority has been set by a ready command; only these may
	// be delayed, so an expiry never reads an unset priority
	bit        prio_known [TASK_SLOTS];

	status_word_t expected_words[$];
	int  errors;
	int  words_checked;
	int  notices_seen;
	int  cmds_sent;
	bit  calm;

	function automatic void queue_drop(int t);
		int p;
		p = task_prio[t];
		for (int i = 0; i < rq_len[p]; i++) begin
			if (rq_slot[p][i] == t) begin
				for (int j = i; j + 1 < rq_len[p]; j++)
					rq_slot[p][j] = rq_slot[p][j + 1];
				rq_len[p]--;
				return;
			end
		end
	endfunction

	function automatic void queue_push_head(int t, int p);
		queue_drop(t);
		task_prio[t] = p[4:0];
		if (rq_len[p] >= TASK_SLOTS)
			return;
		for (int j = rq_len[p]; j > 0; j--)
			rq_slot[p][j] = rq_slot[p][j - 1];
		rq_slot[p][0] = t[3:0];
		rq_len[p]++;
	endfunction

	function automatic void delay_drop_at(int i);
		for (int j = i; j + 1 < dl_len; j++)
			dl_slot[j] = dl_slot[j + 1];
		dl_len--;
	endfunction

	function automatic void delay_drop(int t);
		for (int i = 0; i < dl_len; i++) begin
			if (dl_slot[i] == t) begin
				delay_drop_at(i);
				return;
			end
		end
	endfunction

	function automatic void pick_highest();
		for (int p = 0; p < PRIO_LEVELS; p++) begin
			if (rq_len[p] > 0) begin
				running = rq_slot[p][0];
				return;
			end
		end
	endfunction

	function automatic void slice_step();
		int t, p, n;
		bit [3:0] head;
		t = running;
		p = task_prio[t];
		n = rq_len[p];
		task_slice[t] = task_slice[t] - 8'd1;
		if (task_slice[t] != 0 || n == 0)
			return;
		head = rq_slot[p][0];
		for (int j = 0; j + 1 < n; j++)
			rq_slot[p][j] = rq_slot[p][j + 1];
		rq_slot[p][n - 1] = head;
		task_slice[t] = slice_value;
	endfunction

	function automatic void sched_reset();
		for (int p = 0; p < PRIO_LEVELS; p++)
			rq_len[p] = 0;
		for (int t = 0; t < TASK_SLOTS; t++) begin
			task_prio[t] = 0;
			task_evt[t] = 0;
			task_wait[t] = 0;
			task_slice[t] = SLICE_RESET;
			prio_known[t] = 0;
		end
		dl_len = 0;
		running = 0;
		lock_depth = 0;
		slice_value = SLICE_RESET;
	endfunction

	// apply one command to the model and queue the words it must produce
	function automatic void sched_apply(bit [3:0] op, bit [3:0] t, bit [4:0] prio,
			bit [31:0] ticks, bit waits);
		bit [3:0] was;
		int i, d;
		status_word_t w;
		was = running;
		case (op)
			CMD_READY: begin
				queue_push_head(t, prio);
				prio_known[t] = 1;
			end
			CMD_UNREADY: queue_drop(t);
			CMD_DELAY: begin
				delay_drop(t);
				task_wait[t] = ticks;
				task_evt[t] = waits;
				if (dl_len < TASK_SLOTS) begin
					dl_slot[dl_len] = t;
					dl_len++;
				end
			end
			CMD_WAKE: delay_drop(t);
			CMD_TICK: begin
				i = 0;
				while (i < dl_len) begin
					d = dl_slot[i];
					task_wait[d] = task_wait[d] - 32'd1;
					if (task_wait[d] == 0) begin
						if (task_evt[d]) begin
							task_evt[d] = 0;
							w = '{kind: 1'b0, tsk: d[3:0], sw: 1'b0, lvl: 8'd0, fin: 1'b0};
							expected_words.push_back(w);
						end
						delay_drop_at(i);
						queue_push_head(d, task_prio[d]);
					end else begin
						i++;
					end
				end
				slice_step();
				if (lock_depth == 0)
					pick_highest();
			end
			CMD_LOCK: if (lock_depth != LOCK_MAX) lock_depth++;
			CMD_UNLOCK: begin
				if (lock_depth != 0) begin
					lock_depth--;
					if (lock_depth == 0)
						pick_highest();
				end
			end
			CMD_SCHEDULE: if (lock_depth == 0) pick_highest();
			CMD_START: pick_highest();
			default: ;
		endcase
		w = '{kind: 1'b1, tsk: running, sw: running != was, lvl: lock_depth, fin: 1'b1};
		expected_words.push_back(w);
	endfunction

	// ---------------------------------------------------------------
	// Checking
	// ---------------------------------------------------------------
	task automatic report_mismatch(string what, int got, int want);
		errors++;
		$display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
	endtask

	always @(posedge clk) begin
		status_word_t w;
		if (arst_n && res.valid && res.ready) begin
			if (expected_words.size() == 0) begin
				report_mismatch("unexpected result word", res.task_out, -1);
			end else begin
				w = expected_words.pop_front();
				words_checked++;
				if (!w.kind)
					notices_seen++;
				if (res.kind !== w.kind)
					report_mismatch("kind", res.kind, w.kind);
				if (res.task_out !== w.tsk)
					report_mismatch("task_out", res.task_out, w.tsk);
				if (res.switched !== w.sw)
					report_mismatch("switched", res.switched, w.sw);
				if (res.lock_level !== w.lvl)
					report_mismatch("lock_level", res.lock_level, w.lvl);
				if (res.last !== w.fin)
					report_mismatch("last", res.last, w.fin);
			end
		end
	end

	// result side: random stall bursts unless calm
	initial begin
		int n;
		res.ready <= 1'b0;
		@(posedge clk);
		forever begin
			if (calm || $urandom_range(0, 2) == 0) begin
				res.ready <= 1'b1;
				n = $urandom_range(1, 10);
			end else begin
				res.ready <= 1'b0;
				n = $urandom_range(1, 10);
			end
			repeat (n) @(posedge clk);
		end
	end

	// watchdog: cycles without any handshake
	int quiet_cycles = 0;
	always @(posedge clk) begin
		if ((cmd.valid && cmd.ready) || (res.valid && res.ready) || (cfg.valid && cfg.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > 5000) begin
			$display("timeout: no handshake for %0d cycles", quiet_cycles);
			$display("priority_task_scheduler_unit verification failed");
			$finish;
		end
	end

	// ---------------------------------------------------------------
	// Stimulus helpers
	// ---------------------------------------------------------------
	task automatic send_cmd(bit [3:0] op, bit [3:0] t, bit [4:0] prio, bit [31:0] ticks,
			bit waits);
		int gap;
		cmd.valid          <= 1'b1;
		cmd.command        <= op;
		cmd.task_id        <= t;
		cmd.ready_priority <= prio;
		cmd.delay_ticks    <= ticks;
		cmd.waits_event    <= waits;
		@(posedge clk);
		while (!cmd.ready)
			@(posedge clk);
		sched_apply(op, t, prio, ticks, waits);
		cmds_sent++;
		// random gap on the command side
		if (!calm && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 10);
			cmd.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain();
		cmd.valid <= 1'b0;
		@(posedge clk);
		while (expected_words.size() != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	task automatic write_slice(bit [7:0] v);
		drain();
		cfg.valid <= 1'b1;
		cfg.data  <= v;
		@(posedge clk);
		while (!cfg.ready)
			@(posedge clk);
		cfg.valid <= 1'b0;
		slice_value = v;
	endtask

	function automatic bit [3:0] known_task();
		bit [3:0] t;
		do t = 4'($urandom_range(0, 15)); while (!prio_known[t]);
		return t;
	endfunction

	// ---------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------
	task automatic test_directed();
		// task 0 is running from reset, so give it a priority first
		send_cmd(CMD_READY, 4'd0, 5'd0, 32'd0, 1'b0);
		send_cmd(CMD_READY, 4'd15, 5'd31, 32'hFFFF_FFFF, 1'b1);
		send_cmd(CMD_READY, 4'd5, 5'd5, 32'd0, 1'b0);
		send_cmd(CMD_READY, 4'd6, 5'd5, 32'd0, 1'b0);
		send_cmd(CMD_READY, 4'd5, 5'd5, 32'd0, 1'b0);  // already queued
		send_cmd(CMD_UNREADY, 4'd0, 5'd0, 32'd0, 1'b0);
		send_cmd(CMD_UNREADY, 4'd0, 5'd0, 32'd0, 1'b0); // not queued any more
		send_cmd(CMD_SCHEDULE, 4'd0, 5'd0, 32'd0, 1'b0);
		send_cmd(CMD_LOCK, 4'd0, 5'd0, 32'd0, 1'b0);
		send_cmd(CMD_READY, 4'd10, 5'd1, 32'd0, 1'b0);
		send_cmd(CMD_SCHEDULE, 4'd0, 5'd0, 32'd0, 1'b0); // locked: no change
		send_cmd(CMD_START, 4'd0, 5'd0, 32'd0, 1'b0);    // start ignores lock
		send_cmd(CMD_UNLOCK, 4'd0, 5'd0, 32'd0, 1'b0);
		send_cmd(CMD_UNLOCK, 4'd0, 5'd0, 32'd0, 1'b0);   // already zero
		send_cmd(CMD_DELAY, 4'd6, 5'd0, 32'd1, 1'b1);
		send_cmd(CMD_DELAY, 4'd5, 5'd0, 32'd3, 1'b0);
		send_cmd(CMD_DELAY, 4'd6, 5'd0, 32'd2, 1'b1);    // already delayed
		send_cmd(CMD_DELAY, 4'd15, 5'd0, 32'd0, 1'b1);   // zero: wraps, never expires here
		send_cmd(CMD_TICK, 4'd0, 5'd0, 32'd0, 1'b0);
		send_cmd(CMD_TICK, 4'd0, 5'd0, 32'd0, 1'b0);
		send_cmd(CMD_WAKE, 4'd5, 5'd0, 32'd0, 1'b0);
		send_cmd(CMD_WAKE, 4'd5, 5'd0, 32'd0, 1'b0);     // not delayed
		send_cmd(CMD_WAKE, 4'd15, 5'd0, 32'd0, 1'b0);
		send_cmd(4'd9, 4'd3, 5'd3, 32'd3, 1'b1);         // unknown commands
		send_cmd(4'd15, 4'd12, 5'd26, 32'd12, 1'b0);
	endtask

	task automatic test_lock_nesting();
		// nested locks hold scheduling until the outermost unlock
		repeat (3) send_cmd(CMD_LOCK, 4'd0, 5'd0, 32'd0, 1'b0);
		send_cmd(CMD_SCHEDULE, 4'd0, 5'd0, 32'd0, 1'b0);
		send_cmd(CMD_TICK, 4'd0, 5'd0, 32'd0, 1'b0);
		repeat (4) send_cmd(CMD_UNLOCK, 4'd0, 5'd0, 32'd0, 1'b0);
	endtask

	task automatic test_slice_expiry();
		// reload of one: a slice reloaded to this value expires on a single tick, rotating the running task's queue
		write_slice(8'd1);
		send_cmd(CMD_READY, 4'd1, 5'd2, 32'd0, 1'b0);
		send_cmd(CMD_READY, 4'd2, 5'd2, 32'd0, 1'b0);
		send_cmd(CMD_READY, 4'd3, 5'd2, 32'd0, 1'b0);
		send_cmd(CMD_START, 4'd0, 5'd0, 32'd0, 1'b0);
		repeat (12) send_cmd(CMD_TICK, 4'd0, 5'd0, 32'd0, 1'b0);
	endtask

	task automatic test_random(int count);
		int sel;
		bit [31:0] ticks;
		for (int n = 0; n < count; n++) begin
			sel = $urandom_range(0, 99);
			if (sel < 20) begin
				send_cmd(CMD_READY, 4'($urandom_range(0, 15)), 5'($urandom_range(0, 31)),
					$urandom, 1'($urandom_range(0, 1)));
			end else if (sel < 38) begin
				ticks = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(1, 4);
				send_cmd(CMD_DELAY, known_task(), 5'($urandom_range(0, 31)), ticks,
					1'($urandom_range(0, 1)));
			end else if (sel < 65) begin
				send_cmd(CMD_TICK, 4'($urandom_range(0, 15)), 5'($urandom_range(0, 31)),
					$urandom, 1'($urandom_range(0, 1)));
			end else if (sel < 71) begin
				send_cmd(CMD_UNREADY, 4'($urandom_range(0, 15)), 5'd0, 32'd0, 1'b0);
			end else if (sel < 76) begin
				send_cmd(CMD_WAKE, 4'($urandom_range(0, 15)), 5'd0, 32'd0, 1'b0);
			end else if (sel < 82) begin
				send_cmd(CMD_LOCK, 4'd0, 5'd0, 32'd0, 1'b0);
			end else if (sel < 89) begin
				send_cmd(CMD_UNLOCK, 4'd0, 5'd0, 32'd0, 1'b0);
			end else if (sel < 94) begin
				send_cmd(CMD_SCHEDULE, 4'd0, 5'd0, 32'd0, 1'b0);
			end else if (sel < 97) begin
				send_cmd(CMD_START, 4'd0, 5'd0, 32'd0, 1'b0);
			end else begin
				send_cmd(4'($urandom_range(9, 15)), 4'($urandom_range(0, 15)),
					5'($urandom_range(0, 31)), $urandom, 1'($urandom_range(0, 1)));
			end
		end
	endtask

	// ---------------------------------------------------------------
	// Main sequence
	// ---------------------------------------------------------------
	initial begin
		arst_n             = 1'b0;
		calm               = 1'b0;
		errors             = 0;
		words_checked      = 0;
		notices_seen       = 0;
		cmds_sent          = 0;
		cmd.valid          <= 1'b0;
		cmd.command        <= '0;
		cmd.task_id        <= '0;
		cmd.ready_priority <= '0;
		cmd.delay_ticks    <= '0;
		cmd.waits_event    <= 1'b0;
		cfg.valid          <= 1'b0;
		cfg.data           <= '0;
		sched_reset();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random(40);
		test_lock_nesting();
		test_slice_expiry();
		test_random(40);
		write_slice(8'd255);
		test_random(35);
		write_slice(8'd3);
		calm = 1'b1;
		test_random(35);

		drain();
		$display("covered %0d commands, %0d result words (%0d timeout notices)",
			cmds_sent, words_checked, notices_seen);
		$display("slice reload settings 10, 1, 255 and 3; nested locks and unlock at zero");
		if (errors == 0 && expected_words.size() == 0) begin
			$display("priority_task_scheduler_unit verification clean");
		end else begin
			$display("%0d mismatches, %0d words still expected", errors, expected_words.size());
			$display("priority_task_scheduler_unit verification failed");
		end
		$finish;
	end

endmodule
